/* hdl/bafr_pkg.sv */
// bafr_pkg: constants, codes and write-port structs for the bump allocator
// with first-fit reuse. no dependencies; used by bafr_slot_store and the top level.
`timescale 1ns / 1ps

package bafr_pkg;

  localparam int POOL_BYTES   = 1024;
  localparam int ALIGN_SHIFT  = 3;
  localparam int ALIGN_BYTES  = 1 << ALIGN_SHIFT;
  localparam int HEADER_BYTES = 16;
  localparam int SLOT_COUNT   = POOL_BYTES / ALIGN_BYTES;
  localparam int SLOT_W       = $clog2(SLOT_COUNT);
  localparam int LINK_W       = SLOT_W + 1;
  localparam int ADDR_W       = 11;
  localparam int SIZE_W       = 11;
  localparam int KIND_W       = 2;
  localparam int SUM_W        = ADDR_W + 1;

  localparam logic [LINK_W-1:0] NULL_SLOT = LINK_W'(SLOT_COUNT);

  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESET = 2'd2;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    logic [LINK_W-1:0] data;
  } link_wr_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    logic [SIZE_W-1:0] data;
  } size_wr_t;

  typedef struct packed {
    logic [LINK_W-1:0] link;
    logic [SIZE_W-1:0] size;
  } slot_rd_t;

endpackage

/* hdl/bafr_slot_store.sv */
// bafr_slot_store: per-slot link and size memories, one shared read address,
// registered read data, a write port each. depends on bafr_pkg.
`timescale 1ns / 1ps

module bafr_slot_store (
  input  logic                           clk,
  input  logic [bafr_pkg::SLOT_W-1:0]    rd_addr,
  output bafr_pkg::slot_rd_t             rd,
  input  bafr_pkg::link_wr_t             link_wr,
  input  bafr_pkg::size_wr_t             size_wr
);
  import bafr_pkg::*;

  logic [LINK_W-1:0] link_mem [SLOT_COUNT];
  logic [SIZE_W-1:0] size_mem [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (link_wr.en) begin
      link_mem[link_wr.addr] <= link_wr.data;
    end
    if (size_wr.en) begin
      size_mem[size_wr.addr] <= size_wr.data;
    end
    rd.link <= link_mem[rd_addr];
    rd.size <= size_mem[rd_addr];
  end

endmodule

/* hdl/bump_allocator_first_fit_reuse.sv */
// bump_allocator_first_fit_reuse: top level, command sequencer, free-list walk
// and bump path. depends on bafr_pkg and bafr_slot_store.
//
//   channel   signals                                        handshake
//   command   kind, request_size, block_address              start high while busy low
//   result    status, payload_offset, reused                 done, one cycle, no stall
//
// free, reset and unknown commands: result in the cycle after the command, busy stays low.
// alloc: walks the free list, one link memory read per link visited, then takes the
// bump path on a miss or an empty list; busy high meanwhile.
// rst is synchronous: empty free list, bump offset zero. the slot memories are not
// cleared; the block does not check that a slot is written before it is read.
`timescale 1ns / 1ps

module bump_allocator_first_fit_reuse (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [bafr_pkg::KIND_W-1:0]   kind,
  input  logic [bafr_pkg::SIZE_W-1:0]   request_size,
  input  logic [bafr_pkg::ADDR_W-1:0]   block_address,
  output logic                          done,
  output logic                          status,
  output logic [bafr_pkg::ADDR_W-1:0]   payload_offset,
  output logic                          reused
);
  import bafr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_BUMP = 3'b100
  } state_t;

  state_t            state;
  logic [LINK_W-1:0] head;
  logic [ADDR_W-1:0] bump;
  logic [SIZE_W-1:0] req;
  logic [SLOT_W-1:0] cur;
  logic [LINK_W-1:0] prev;
  logic [SLOT_W-1:0] steps;

  logic [SLOT_W-1:0] rd_addr;
  slot_rd_t          rd;
  link_wr_t          link_wr;
  size_wr_t          size_wr;

  logic              accept;
  logic              hit;
  logic              walk_last;
  logic [ADDR_W-1:0] hdr;
  logic              free_ok;
  logic [SLOT_W-1:0] free_slot;
  logic [SUM_W-1:0]  rounded;
  logic [SUM_W-1:0]  end_sum;
  logic              fits;
  logic [ADDR_W-1:0] hit_offset;
  logic [SUM_W-1:0]  bump_payload;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  bafr_slot_store u_store (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd      (rd),
    .link_wr (link_wr),
    .size_wr (size_wr)
  );

  always_comb begin
    hit       = (req <= rd.size);
    walk_last = (steps == SLOT_W'(SLOT_COUNT - 1)) || (rd.link >= NULL_SLOT);
    rd_addr   = (state == S_IDLE) ? head[SLOT_W-1:0] : rd.link[SLOT_W-1:0];

    // free address must sit past the header, on the alignment grid, inside the store
    hdr       = block_address - ADDR_W'(HEADER_BYTES);
    free_slot = hdr[ALIGN_SHIFT +: SLOT_W];
    free_ok   = (block_address >= ADDR_W'(HEADER_BYTES))
             && (hdr[ALIGN_SHIFT-1:0] == '0)
             && ((hdr >> ALIGN_SHIFT) < ADDR_W'(SLOT_COUNT));

    rounded      = (SUM_W'(bump) + SUM_W'(ALIGN_BYTES - 1))
                 & ~SUM_W'(ALIGN_BYTES - 1);
    end_sum      = rounded + SUM_W'(HEADER_BYTES) + SUM_W'(req);
    fits         = (end_sum <= SUM_W'(POOL_BYTES));
    bump_payload = rounded + SUM_W'(HEADER_BYTES);
    hit_offset   = ADDR_W'({cur, ALIGN_SHIFT'(0)}) + ADDR_W'(HEADER_BYTES);

    link_wr = '0;
    if (state == S_IDLE && accept && kind == KIND_FREE && free_ok) begin
      link_wr.en   = 1'b1;
      link_wr.addr = free_slot;
      link_wr.data = head;
    end else if (state == S_WALK && hit && prev != NULL_SLOT) begin
      // unlink a slot that is not the list head
      link_wr.en   = 1'b1;
      link_wr.addr = prev[SLOT_W-1:0];
      link_wr.data = rd.link;
    end

    size_wr      = '0;
    size_wr.en   = (state == S_BUMP) && fits;
    size_wr.addr = rounded[ALIGN_SHIFT +: SLOT_W];
    size_wr.data = req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= NULL_SLOT;
      bump  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (kind)
              KIND_ALLOC: begin
                req   <= request_size;
                cur   <= head[SLOT_W-1:0];
                prev  <= NULL_SLOT;
                steps <= '0;
                state <= (head == NULL_SLOT) ? S_BUMP : S_WALK;
              end
              KIND_FREE: begin
                if (free_ok) begin
                  head <= LINK_W'(free_slot);
                end
              end
              KIND_RESET: begin
                head <= NULL_SLOT;
                bump <= '0;
              end
              default: begin
              end
            endcase
            if (kind != KIND_ALLOC) begin
              done           <= 1'b1;
              status         <= 1'b0;
              payload_offset <= '0;
              reused         <= 1'b0;
            end
          end
        end
        S_WALK: begin
          // read data for cur arrived this cycle
          if (hit) begin
            if (prev == NULL_SLOT) begin
              head <= rd.link;
            end
            done           <= 1'b1;
            status         <= 1'b0;
            payload_offset <= hit_offset;
            reused         <= 1'b1;
            state          <= S_IDLE;
          end else begin
            prev  <= LINK_W'(cur);
            cur   <= rd.link[SLOT_W-1:0];
            steps <= steps + SLOT_W'(1);
            if (walk_last) begin
              state <= S_BUMP;
            end
          end
        end
        S_BUMP: begin
          done   <= 1'b1;
          reused <= 1'b0;
          state  <= S_IDLE;
          if (fits) begin
            bump           <= end_sum[ADDR_W-1:0];
            status         <= 1'b0;
            payload_offset <= bump_payload[ADDR_W-1:0];
          end else begin
            status         <= 1'b1;
            payload_offset <= '0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
